// File: src/srs_pkg.sv
// Shared types and constants for the stripe request splitter.
// Used by srs_div and stripe_request_splitter; depends on nothing else.
package srs_pkg;

	// Stripe set limits and field widths.
	localparam int MAX_VOLUMES = 16;
	localparam int ADDR_W      = 40;
	localparam int VOL_W       = 4;
	localparam int NVOL_W      = 5;
	localparam int BLK_W       = 17;
	localparam int LEN_W       = 16;
	localparam int MIN_BLK_LOG = 12;
	// Stripe width n * block size needs VOL_W bits above the largest block.
	localparam int STRIPE_W    = BLK_W + VOL_W;
	// Stripe cycle number: position divided by at least the smallest block.
	localparam int CYC_W       = ADDR_W - MIN_BLK_LOG;
	localparam int STEP_W      = $clog2(ADDR_W + 1);
	// Quotient bits needed to find the volume inside one stripe cycle.
	localparam int FV_STEPS    = VOL_W;

	// Block size limits and the default used for a zero block size.
	localparam logic [BLK_W-1:0] DEFAULT_BLOCK = BLK_W'(8192);
	localparam logic [BLK_W-1:0] MIN_BLOCK     = BLK_W'(4096);
	localparam logic [BLK_W-1:0] MAX_BLOCK     = BLK_W'(65536);

	// Configuration register indexes.
	localparam logic CFG_NUM_VOLUMES = 1'b0;
	localparam logic CFG_BLOCK_SIZE  = 1'b1;

	// Result kinds.
	localparam logic KIND_SEEK  = 1'b0;
	localparam logic KIND_CHUNK = 1'b1;

	// Remembered access direction.
	localparam logic [1:0] DIR_NONE  = 2'd0;
	localparam logic [1:0] DIR_READ  = 2'd1;
	localparam logic [1:0] DIR_WRITE = 2'd2;

	// Command to the shared divider.
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} srs_div_cmd_t;

	// Status from the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} srs_div_sts_t;

endpackage

// File: src/srs_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by both
// divisions of a request. Depends on srs_pkg.
module srs_div import srs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  srs_div_cmd_t        cmd,
	input  logic [STRIPE_W-1:0] init_rem,
	input  logic [ADDR_W-1:0]   dividend,
	input  logic [STRIPE_W-1:0] divisor,
	output srs_div_sts_t        sts,
	output logic [ADDR_W-1:0]   quotient,
	output logic [STRIPE_W-1:0] remainder
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [STRIPE_W-1:0] rem_q;
	logic [ADDR_W-1:0]   dvd_q;
	logic [ADDR_W-1:0]   quo_q;
	logic [STRIPE_W:0]   shifted;
	logic [STRIPE_W+1:0] diff;
	logic                fits;

	// One trial subtraction of the divisor from the shifted partial remainder.
	assign shifted = {rem_q, dvd_q[ADDR_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign fits    = !diff[STRIPE_W+1];

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder, dividend bits and quotient bits.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= init_rem;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[STRIPE_W-1:0] : shifted[STRIPE_W-1:0];
			dvd_q <= {dvd_q[ADDR_W-2:0], 1'b0};
			quo_q <= {quo_q[ADDR_W-2:0], fits};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: src/stripe_request_splitter.sv
// An accepted request passes the setup state, the two divisions, the base
// multiply state and the output register before its first result leaves.
// A new request is taken only in idle, after the last result (n seeks, chunks)
// of the previous one; results go out one per cycle while m_tready holds.
// Reset: arst_n clears the sequencer, the expected position and direction,
// and loads one volume with an 8192-byte block.
module stripe_request_splitter import srs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [BLK_W-1:0]    cfg_wdata,
	// Request in.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [55:0]         s_tdata,   // first_byte[39:0], length[55:40]
	input  logic                s_tuser,   // req_type
	// Results out.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [79:0]         m_tdata,   // volume[3:0], volume_offset[43:4],
	                                       // chunk_length[60:44],
	                                       // buffer_offset[76:61], zeros
	output logic                m_tuser,   // kind
	output logic                m_tlast    // last
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_DIVA  = 3'd2;
	localparam logic [2:0] ST_DIVB  = 3'd3;
	localparam logic [2:0] ST_BASE  = 3'd4;
	localparam logic [2:0] ST_SEEK  = 3'd5;
	localparam logic [2:0] ST_CHUNK = 3'd6;

	logic [2:0]          state_q;
	logic [NVOL_W-1:0]   num_volumes_q;
	logic [BLK_W-1:0]    block_size_q;
	logic [ADDR_W:0]     next_pos_q;
	logic [1:0]          last_dir_q;

	logic [ADDR_W-1:0]   first_q;
	logic [LEN_W-1:0]    len_q;
	logic                disc_q;
	logic [VOL_W-1:0]    nm1_q;
	logic [BLK_W-1:0]    bs_q;
	logic [STRIPE_W-1:0] w_q;
	logic [CYC_W-1:0]    cyc_q;
	logic [VOL_W-1:0]    fv_q;
	logic [BLK_W-1:0]    rb_q;
	logic [ADDR_W-1:0]   base_q;
	logic [VOL_W-1:0]    v_q;
	logic [LEN_W-1:0]    left_q;
	logic [LEN_W-1:0]    boff_q;
	logic                first_chunk_q;

	logic                m_valid_q;
	logic [79:0]         m_data_q;
	logic                m_kind_q;
	logic                m_last_q;

	logic                s_accept;
	logic [1:0]          req_dir;
	logic                req_disc;
	logic [ADDR_W-1:0]   req_first;
	logic [LEN_W-1:0]    req_len;
	logic [VOL_W-1:0]    n_m1;
	logic [BLK_W-1:0]    bs_eff;
	logic [STRIPE_W-1:0] stripe_w;
	logic [CYC_W+BLK_W-1:0] base_prod;

	srs_div_cmd_t        div_cmd;
	srs_div_sts_t        div_sts;
	logic [STRIPE_W-1:0] div_init;
	logic [ADDR_W-1:0]   div_dvd;
	logic [STRIPE_W-1:0] div_dsr;
	logic [ADDR_W-1:0]   div_quo;
	logic [STRIPE_W-1:0] div_rem;

	logic                out_free;
	logic                emit;
	logic [BLK_W-1:0]    seek_add;
	logic [ADDR_W-1:0]   seek_off;
	logic                seek_last;
	logic [BLK_W-1:0]    cur_piece;
	logic [BLK_W-1:0]    piece;
	logic                chunk_last;
	logic [ADDR_W-1:0]   chunk_off;
	logic [VOL_W-1:0]    v_next;

	assign req_first = s_tdata[ADDR_W-1:0];
	assign req_len   = s_tdata[ADDR_W+LEN_W-1:ADDR_W];
	assign req_dir   = s_tuser ? DIR_WRITE : DIR_READ;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign req_disc  = (next_pos_q != {1'b0, req_first}) || (last_dir_q != req_dir);

	// Effective stripe geometry from the configuration registers.
	always_comb begin
		if (num_volumes_q == '0) begin
			n_m1 = '0;
		end else if (num_volumes_q > NVOL_W'(MAX_VOLUMES)) begin
			n_m1 = VOL_W'(MAX_VOLUMES - 1);
		end else begin
			n_m1 = VOL_W'(num_volumes_q - NVOL_W'(1));
		end
		if (block_size_q == '0) begin
			bs_eff = DEFAULT_BLOCK;
		end else if (block_size_q < MIN_BLOCK) begin
			bs_eff = MIN_BLOCK;
		end else if (block_size_q > MAX_BLOCK) begin
			bs_eff = MAX_BLOCK;
		end else begin
			bs_eff = block_size_q;
		end
	end
	assign stripe_w  = STRIPE_W'({1'b0, n_m1} + NVOL_W'(1)) * STRIPE_W'(bs_eff);
	assign base_prod = (CYC_W+BLK_W)'(cyc_q) * (CYC_W+BLK_W)'(bs_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_volumes_q <= NVOL_W'(1);
			block_size_q  <= DEFAULT_BLOCK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_VOLUMES: num_volumes_q <= cfg_wdata[NVOL_W-1:0];
				CFG_BLOCK_SIZE:  block_size_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Divider commands: stripe cycle first, then the volume within the cycle.
	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.steps = STEP_W'(ADDR_W);
		div_init      = '0;
		div_dvd       = first_q;
		if (state_q == ST_SETUP) begin
			div_cmd.start = 1'b1;
		end else if (state_q == ST_DIVA && div_sts.done) begin
			div_cmd.start = 1'b1;
			div_cmd.steps = STEP_W'(FV_STEPS);
			div_init      = div_rem >> FV_STEPS;
			div_dvd       = {div_rem[FV_STEPS-1:0], (ADDR_W-FV_STEPS)'(0)};
		end
	end
	assign div_dsr = (state_q == ST_DIVB) ? STRIPE_W'(bs_q) : w_q;

	srs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.init_rem  (div_init),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Seek result: volumes before the start volume sit one block further.
	always_comb begin
		if (v_q < fv_q) begin
			seek_add = bs_q;
		end else if (v_q == fv_q) begin
			seek_add = rb_q;
		end else begin
			seek_add = '0;
		end
	end
	assign seek_off  = base_q + ADDR_W'(seek_add);
	assign seek_last = (v_q == nm1_q) && (len_q == '0);

	// Chunk result: the first piece runs to the end of its block.
	assign cur_piece  = first_chunk_q ? (bs_q - rb_q) : bs_q;
	assign chunk_last = ({1'b0, left_q} <= cur_piece);
	assign piece      = chunk_last ? {1'b0, left_q} : cur_piece;
	assign chunk_off  = base_q + (first_chunk_q ? ADDR_W'(rb_q) : '0);
	assign v_next     = (v_q == nm1_q) ? '0 : v_q + VOL_W'(1);

	assign out_free = !m_valid_q || m_tready;
	assign emit     = ((state_q == ST_SEEK) || (state_q == ST_CHUNK)) && out_free;

	// Sequencer and request state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_pos_q <= '0;
			last_dir_q <= DIR_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						next_pos_q <= {1'b0, req_first} + (ADDR_W+1)'(req_len);
						if (req_disc && req_len != '0) begin
							last_dir_q <= req_dir;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_DIVA;
				ST_DIVA: begin
					if (div_sts.done) begin
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					if (div_sts.done) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (disc_q) begin
						state_q <= ST_SEEK;
					end else if (len_q != '0) begin
						state_q <= ST_CHUNK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEEK: begin
					if (emit && v_q == nm1_q) begin
						state_q <= (len_q != '0) ? ST_CHUNK : ST_IDLE;
					end
				end
				ST_CHUNK: begin
					if (emit && chunk_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload and walk registers.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			first_q <= req_first;
			len_q   <= req_len;
			disc_q  <= req_disc;
		end
		if (state_q == ST_SETUP) begin
			nm1_q <= n_m1;
			bs_q  <= bs_eff;
			w_q   <= stripe_w;
		end
		if (state_q == ST_DIVA && div_sts.done) begin
			cyc_q <= div_quo[CYC_W-1:0];
		end
		if (state_q == ST_DIVB && div_sts.done) begin
			fv_q <= div_quo[VOL_W-1:0];
			rb_q <= div_rem[BLK_W-1:0];
		end
		if (state_q == ST_BASE) begin
			base_q        <= base_prod[ADDR_W-1:0];
			v_q           <= disc_q ? '0 : fv_q;
			left_q        <= len_q;
			boff_q        <= '0;
			first_chunk_q <= 1'b1;
		end
		if (state_q == ST_SEEK && emit) begin
			v_q <= (v_q == nm1_q) ? fv_q : v_q + VOL_W'(1);
		end
		if (state_q == ST_CHUNK && emit) begin
			left_q        <= left_q - piece[LEN_W-1:0];
			boff_q        <= boff_q + piece[LEN_W-1:0];
			first_chunk_q <= 1'b0;
			v_q           <= v_next;
			if (v_q == nm1_q) begin
				base_q <= base_q + ADDR_W'(bs_q);
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (state_q == ST_SEEK) begin
				m_data_q <= {3'b000, LEN_W'(0), BLK_W'(0), seek_off, v_q};
				m_kind_q <= KIND_SEEK;
				m_last_q <= seek_last;
			end else begin
				m_data_q <= {3'b000, boff_q, piece, chunk_off, v_q};
				m_kind_q <= KIND_CHUNK;
				m_last_q <= chunk_last;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	// The chunk walk never runs with nothing left to move.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHUNK) |-> (left_q != '0))
		else $error("chunk walk with zero bytes left");

	// The shared divider is idle while results are emitted.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEEK) || (state_q == ST_CHUNK)) |-> !div_sts.busy)
		else $error("divider busy during result emission");

	// Seeks carry no length and no buffer offset; chunks always move bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((m_kind_q == KIND_SEEK) ? (m_data_q[76:44] == '0)
		                                       : (m_data_q[60:44] != '0)))
		else $error("result length does not match its kind");

	// A chunk advances the buffer offset by exactly the emitted length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHUNK && emit && !chunk_last) |=>
		(boff_q == $past(boff_q) + $past(piece[LEN_W-1:0])))
		else $error("buffer offset out of step with chunk length");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stripe_request_splitter: drives read and write requests,
// predicts every seek and transfer chunk, and checks them in order. Depends on srs_pkg.
module tb;
	import srs_pkg::*;

	localparam int IDLE_GAP    = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int NUM_PHASES  = 10;
	localparam int PHASE_REQS  = 28;

	// One request as the sender sees it.
	typedef struct packed {
		logic              wr;
		logic [ADDR_W-1:0] first;
		logic [LEN_W-1:0]  len;
	} stripe_req_t;

	// One seek or transfer chunk.
	typedef struct packed {
		logic              kind;
		logic [VOL_W-1:0]  volume;
		logic [ADDR_W-1:0] voff;
		logic [BLK_W-1:0]  clen;
		logic [LEN_W-1:0]  boff;
		logic              last;
	} stripe_result_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = CFG_NUM_VOLUMES;
	logic [BLK_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [55:0]      s_tdata   = '0;   // first_byte[39:0], length[55:40]
	logic             s_tuser   = 1'b0; // req_type
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [79:0]      m_tdata;          // volume[3:0], volume_offset[43:4],
	                                    // chunk_length[60:44], buffer_offset[76:61]
	logic             m_tuser;          // kind
	logic             m_tlast;          // last

	stripe_request_splitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Request queue, predicted results and the model's own copy of state and registers.
	stripe_req_t    request_queue [$];
	stripe_result_t split_results [$];
	logic [NVOL_W-1:0] nvol_reg = NVOL_W'(1);
	logic [BLK_W-1:0]  blk_reg  = DEFAULT_BLOCK;
	logic [63:0]       next_pos = '0;
	logic [1:0]        last_dir = DIR_NONE;

	// Generator view of where the stream continues.
	logic [63:0] gen_next = '0;
	logic        gen_dir  = 1'b0;

	logic s_fire = 1'b0;
	logic quiet  = 1'b0;
	int   s_gap  = 0;
	int   m_gap  = 0;
	int   queued_cnt   = 0;
	int   accepted_cnt = 0;
	int   results_seen = 0;
	int   fail_cnt     = 0;
	int   phases_run   = 0;
	int   cycle_cnt    = 0;
	int unsigned phase_nvol [NUM_PHASES] = '{16, 16, 1, 1, 5, 0, 31, 17, 0, 16};
	int unsigned phase_blk  [NUM_PHASES] = '{4096, 65536, 4096, 65536, 12288, 0, 100,
		131071, 0, 4096};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Split one request into its seeks and chunks, updating position and direction.
	task automatic split_request(input logic wr, input logic [ADDR_W-1:0] first,
			input logic [LEN_W-1:0] len);
		logic [63:0] n, bs, cyc, rem, fv, base, left, piece, boff, v;
		logic [63:0] place [MAX_VOLUMES];
		logic [1:0]  dir;
		stripe_result_t batch [$];
		stripe_result_t r;
		dir = wr ? DIR_WRITE : DIR_READ;
		n = 64'(nvol_reg);
		if (n == 0) n = 1;
		if (n > MAX_VOLUMES) n = MAX_VOLUMES;
		bs = 64'(blk_reg);
		if (bs == 0) bs = 64'(DEFAULT_BLOCK);
		else if (bs < 64'(MIN_BLOCK)) bs = 64'(MIN_BLOCK);
		else if (bs > 64'(MAX_BLOCK)) bs = 64'(MAX_BLOCK);
		cyc  = 64'(first) / (n * bs);
		rem  = 64'(first) - cyc * n * bs;
		fv   = rem / bs;
		base = cyc * bs;
		for (v = 0; v < n; v++) begin
			if (v < fv) place[v] = base + bs;
			else if (v == fv) place[v] = base + rem % bs;
			else place[v] = base;
		end
		// A break in position or direction repositions every volume first.
		if (next_pos != 64'(first) || last_dir != dir) begin
			for (v = 0; v < n; v++) begin
				r = '0;
				r.kind   = KIND_SEEK;
				r.volume = v[VOL_W-1:0];
				r.voff   = place[v][ADDR_W-1:0];
				batch.push_back(r);
			end
			if (len != 0) last_dir = dir;
		end
		next_pos = 64'(first) + 64'(len);
		// Chunks walk the volumes round-robin from the starting volume.
		v     = fv;
		left  = 64'(len);
		piece = bs - rem % bs;
		boff  = 0;
		while (left > 0) begin
			if (piece > left) piece = left;
			r = '0;
			r.kind   = KIND_CHUNK;
			r.volume = v[VOL_W-1:0];
			r.voff   = place[v][ADDR_W-1:0];
			r.clen   = piece[BLK_W-1:0];
			r.boff   = boff[LEN_W-1:0];
			batch.push_back(r);
			place[v] += piece;
			v++;
			if (v >= n) v = 0;
			left -= piece;
			boff += piece;
			piece = bs;
		end
		if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) split_results.push_back(batch[i]);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
			fail_cnt++;
		end
	endtask

	// Request acceptance: predict at the edge where the handshake completes.
	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			split_request(s_tuser, s_tdata[39:0], s_tdata[55:40]);
			accepted_cnt++;
		end
	end

	// Request driver, fed from the request queue with random gaps.
	always @(negedge clk) begin
		stripe_req_t req;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (s_gap != 0) begin
				s_tvalid <= 1'b0;
				s_gap <= s_gap - 1;
			end else if (request_queue.size() != 0) begin
				req = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {req.len, req.first};
				s_tuser <= req.wr;
				if (!quiet && $urandom_range(0, 7) == 0) s_gap <= $urandom_range(1, 12);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result side back-pressure in random bursts.
	always @(negedge clk) begin
		if (m_gap != 0) begin
			m_tready <= 1'b0;
			m_gap <= m_gap - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			m_gap <= $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result monitor: compare each result with the oldest prediction.
	always @(posedge clk) begin
		stripe_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (split_results.size() == 0) begin
				$error("unexpected result: kind %0d volume %0d offset 0x%0h",
					m_tuser, m_tdata[3:0], m_tdata[43:4]);
				fail_cnt++;
			end else begin
				r = split_results.pop_front();
				check_field("kind", 64'(r.kind), 64'(m_tuser));
				check_field("volume", 64'(r.volume), 64'(m_tdata[3:0]));
				check_field("volume_offset", 64'(r.voff), 64'(m_tdata[43:4]));
				check_field("chunk_length", 64'(r.clen), 64'(m_tdata[60:44]));
				check_field("buffer_offset", 64'(r.boff), 64'(m_tdata[76:61]));
				check_field("last", 64'(r.last), 64'(m_tlast));
				results_seen++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_request(input logic wr, input logic [ADDR_W-1:0] first,
			input logic [LEN_W-1:0] len);
		stripe_req_t req;
		req.wr    = wr;
		req.first = first;
		req.len   = len;
		request_queue.push_back(req);
		queued_cnt++;
		if (len != 0) gen_dir = wr;
		gen_next = 64'(first) + 64'(len);
	endtask

	// Wait until every request is taken and every result is back, then let the block settle.
	task automatic wait_idle();
		do @(negedge clk); while (accepted_cnt != queued_cnt || split_results.size() != 0);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [BLK_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_VOLUMES) nvol_reg = val[NVOL_W-1:0];
		else blk_reg = val;
	endtask

	task automatic set_stripe(input int unsigned nv, input int unsigned bs);
		wait_idle();
		write_reg(CFG_NUM_VOLUMES, BLK_W'(nv));
		write_reg(CFG_BLOCK_SIZE, BLK_W'(bs));
		phases_run++;
	endtask

	// Mostly continuing requests, plus direction flips and jumps anywhere in the file.
	task automatic random_request();
		logic [63:0]       t;
		logic [ADDR_W-1:0] first;
		logic [LEN_W-1:0]  len;
		logic              wr;
		int unsigned       sel, lsel;
		t    = {$urandom, $urandom};
		sel  = $urandom_range(0, 9);
		lsel = $urandom_range(0, 15);
		wr   = gen_dir;
		first = t[ADDR_W-1:0];
		if (sel <= 6 && gen_next < (64'd1 << ADDR_W)) begin
			first = gen_next[ADDR_W-1:0];
			if (sel == 6) wr = ~gen_dir;
		end else if (sel == 7) begin
			wr = t[63];
		end else if (sel == 8) begin
			first = ADDR_W'(t[19:0]);
			wr = t[62];
		end else if (sel == 9) begin
			first = {ADDR_W{1'b1}} - ADDR_W'(t[17:0]);
			wr = t[61];
		end
		if (lsel == 0) len = '0;
		else if (lsel == 1) len = '1;
		else if (lsel <= 5) len = LEN_W'($urandom_range(1, 600));
		else len = LEN_W'($urandom_range(0, 65535));
		queue_request(wr, first, len);
	endtask

	// Stimulus: directed corners, then random phases over several stripe settings.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: first access, zero lengths, direction change, address wrap.
		queue_request(1'b0, 40'd0, 16'd0);
		queue_request(1'b0, 40'd0, 16'd100);
		queue_request(1'b0, 40'd100, 16'd8092);
		queue_request(1'b0, 40'd8192, 16'd0);
		queue_request(1'b1, 40'd8192, 16'hFFFF);
		queue_request(1'b1, 40'd73727, 16'd1);
		queue_request(1'b1, 40'hFF_FFFF_FFFF, 16'hFFFF);
		queue_request(1'b0, 40'hFF_FFFF_FFFF, 16'd0);

		// Widest set with the smallest block gives the most results per request.
		set_stripe(16, 4096);
		queue_request(1'b1, 40'd2050, 16'hFFFF);
		queue_request(1'b1, 40'd67585, 16'hFFFF);
		queue_request(1'b0, 40'h12_3456_7000, 16'd4096);
		queue_request(1'b0, 40'h12_3456_8000, 16'h8000);

		set_stripe(16, 65536);
		queue_request(1'b1, 40'hFF_FFFF_FFFF, 16'hFFFF);
		queue_request(1'b0, 40'd0, 16'hFFFF);
		queue_request(1'b0, 40'h55_5555_5555, 16'h5555);
		queue_request(1'b1, 40'hAA_AAAA_AAAA, 16'hAAAA);

		// Out-of-range register values fall back to the legal limits, zero values to the defaults.
		set_stripe(0, 0);
		queue_request(1'b0, 40'h00_0001_3000, 16'd300);
		set_stripe(31, 1);
		queue_request(1'b1, 40'd12345, 16'hFFFF);
		set_stripe(17, 131071);
		queue_request(1'b0, 40'h80_0000_0000, 16'hFFFF);

		phase_nvol[8] = $urandom_range(1, 16);
		phase_blk[8]  = $urandom_range(4096, 65536);
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_stripe(phase_nvol[p], phase_blk[p]);
			if (p == NUM_PHASES - 1) quiet = 1'b1;
			repeat (PHASE_REQS) random_request();
		end

		wait_idle();
		$display("Run covered %0d requests over %0d stripe settings; %0d results checked.",
			accepted_cnt, phases_run, results_seen);
		if (fail_cnt == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
